// File: rtl/pmfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfp_pkg
// Types and constants shared by the management frame parser.
// ----------------------------------------------------------------------------
package pmfp_pkg;

   localparam int MaxFrameBytes = 2048;
   localparam int PosW = $clog2(MaxFrameBytes + 1);

   localparam logic [15:0] MtDiscList = 16'h0015;
   localparam logic [15:0] MtSetKey   = 16'h6008;
   localparam logic [15:0] MtBridge   = 16'h6021;
   localparam logic [23:0] OuiVendA   = 24'h00B052;
   localparam logic [23:0] OuiVendB   = 24'h0080E1;
   localparam logic [3:0]  StaRecLen  = 4'd12;
   localparam logic [3:0]  NetRecLen  = 4'd13;
   localparam logic [3:0]  BrgRecLen  = 4'd6;
   localparam logic [11:0] KeyMinLen  = 12'd38;

   localparam logic [1:0] StOk = 2'd0, StTiny = 2'd1, StHdrShort = 2'd2, StOuiShort = 2'd3;
   localparam logic [1:0] BkOpaque = 2'd0, BkDisc = 2'd1, BkKey = 2'd2, BkBridge = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE, PH_STA, PH_NETCNT, PH_NET, PH_BRG, PH_DONE
   } phase_type;

   // word passed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [7:0]  version;
      logic [15:0] message_type;
      logic [4:0]  flags;
      logic [3:0]  header_bytes;
      logic [15:0] fragment_info;
      logic [23:0] vendor_oui;
      logic [1:0]  oui_class;
      logic [11:0] pay_len;
      logic [1:0]  body_kind;
      logic [7:0]  body_first;
      logic [7:0]  body_second;
   } result_type;

   function automatic logic known_type(input logic [15:0] mt);
      logic k;
      k = 1'b0;
      case (mt)
         16'h0014, 16'h0015, 16'h0016, 16'h6020, 16'h6021, 16'h6006, 16'h6007,
         16'h6008, 16'h6009, 16'h600C, 16'h600D, 16'h6002, 16'h6038, 16'h6039,
         16'h6048, 16'h6049, 16'h604C, 16'h604D, 16'h0004, 16'h0005, 16'h0030,
         16'h0031, 16'h002C, 16'h002D, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
         16'h000C, 16'h000D, 16'h2000, 16'h2001, 16'h4000, 16'h4001, 16'h4004,
         16'h4005, 16'h4006: k = 1'b1;
         default: k = 1'b0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// File: rtl/powerline_mgmt_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// powerline_mgmt_frame_parser
// Management frame parser: one byte a word in, one result word per frame.
//
//   channel | dir | payload
//   req_    | in  | data_byte, last_byte (tlast)
//   rsp_    | out | result fields, one word per frame
//   csr_    | in  | record_cap
//
// One word per cycle sustained. Once the last byte is taken, the result word
// goes through the queue and then the back part's result register. Bytes past
// the frame limit, except a frame's last byte, are dropped in the front part.
// Reset clears all frame state; record_cap resets to 256.
// A stalled rsp_ side holds the queue, which then fills and lowers req_tready.
// ----------------------------------------------------------------------------
module powerline_mgmt_frame_parser (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire  [8:0]   csr_wdata,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,  // data_byte
   input  wire          req_tlast,  // last_byte
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // frame_status[1:0] version[9:2] message_type[25:10] flags[30:26]
   // header_bytes[34:31] fragment_info[50:35] vendor_oui[74:51]
   // oui_class[76:75] pay_len[88:77] body_kind[90:89]
   // body_first[98:91] body_second[106:99], zero fill to 112
   output logic [111:0] rsp_tdata
);
   logic [8:0] cap_ff;
   pmfp_pkg::word_type fw, qw;
   logic fv, fr, qv, qr;
   pmfp_pkg::result_type r;

   always_ff @(posedge clock) begin
      if (reset)       cap_ff <= 9'd256;
      else if (csr_we) cap_ff <= csr_wdata;
   end

   pmfp_front u_front (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .in_last(req_tlast), .out_valid(fv), .out_ready(fr),
      .out_word(fw));
   pmfp_queue u_queue (.clock, .reset, .in_valid(fv), .in_ready(fr), .in_word(fw),
      .out_valid(qv), .out_ready(qr), .out_word(qw));
   pmfp_back u_back (.clock, .reset, .record_cap(cap_ff), .in_valid(qv), .in_ready(qr),
      .in_word(qw), .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(r));

   assign rsp_tdata = {5'd0, r.body_second, r.body_first, r.body_kind, r.pay_len,
      r.oui_class, r.vendor_oui, r.fragment_info, r.header_bytes, r.flags,
      r.message_type, r.version, r.frame_status};

   a_tiny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == pmfp_pkg::StTiny |-> rsp_tdata[106:2] == '0)
      else $error("short frame result not cleared");
   a_oui_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[74:51] == '0) || (rsp_tdata[76:75] != 2'd0)))
      else $error("OUI present without class");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
endmodule
`default_nettype wire

// File: rtl/pmfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfp_queue
// Two-entry queue of words between the front and back parts.
// ----------------------------------------------------------------------------
module pmfp_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  pmfp_pkg::word_type in_word,
   output logic              out_valid,
   input  wire               out_ready,
   output pmfp_pkg::word_type out_word
);
   pmfp_pkg::word_type mem_ff [2];
   pmfp_pkg::word_type mem_in [2];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_word  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      mem_in = mem_ff;
      if (push) mem_in[wr_ff] = in_word;
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in; wr_ff <= wr_in; cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/pmfp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfp_front
// Takes frame bytes and drops those past the frame limit, keeping the last.
// ----------------------------------------------------------------------------
module pmfp_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_ready,
   input  wire  [7:0]        in_data,
   input  wire               in_last,
   output logic              out_valid,
   input  wire               out_ready,
   output pmfp_pkg::word_type out_word
);
   logic [pmfp_pkg::PosW-1:0] cnt_ff, cnt_in;
   logic keep, acc;

   assign keep      = (cnt_ff < pmfp_pkg::PosW'(pmfp_pkg::MaxFrameBytes)) || in_last;
   assign in_ready  = out_ready || !keep;
   assign out_valid = in_valid && keep;
   assign out_word  = '{data: in_data, last: in_last};
   assign acc       = in_valid && in_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (acc) begin
         if (in_last) cnt_in = '0;
         else if (keep) cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// File: rtl/pmfp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfp_back
// Decodes header and body bytes and registers one result per frame.
// ----------------------------------------------------------------------------
module pmfp_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [8:0]          record_cap,
   input  wire                 in_valid,
   output logic                in_ready,
   input  pmfp_pkg::word_type  in_word,
   output logic                out_valid,
   input  wire                 out_ready,
   output pmfp_pkg::result_type out_res
);
   // byte_position counts only kept bytes; the last may be beyond the limit
   logic [pmfp_pkg::PosW-1:0] pos_ff, pos_in;
   logic [7:0] hdr_ff [8];
   logic [7:0] hdr_in [8];
   pmfp_pkg::phase_type ph_ff, ph_in;
   logic [3:0] rbi_ff, rbi_in;
   logic [7:0] dsta_ff, dsta_in, dnet_ff, dnet_in, csta_ff, csta_in, cnet_ff, cnet_in;
   logic [7:0] prf_ff, prf_in, bf0_ff, bf0_in, bf1_ff, bf1_in;
   logic ov_ff, ov_in;
   pmfp_pkg::result_type res_ff, res_in;

   logic acc, inrange;
   logic [7:0] b;
   logic [15:0] mt;
   logic [pmfp_pkg::PosW-1:0] p, n, off;
   logic [3:0] rbi_nx;
   logic [7:0] cnt_nx;
   logic [2:0] cat;
   logic vend, shorth;
   logic [23:0] oui;
   logic [11:0] plen;

   assign in_ready  = !ov_ff || out_ready;
   assign acc       = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_res   = res_ff;
   assign b         = in_word.data;
   assign mt        = {hdr_ff[2], hdr_ff[1]};
   assign inrange   = pos_ff < pmfp_pkg::PosW'(pmfp_pkg::MaxFrameBytes);
   assign p         = pos_ff - pmfp_pkg::PosW'(5);

   function automatic logic [8:0] capped(input logic [7:0] v, input logic [8:0] c);
      return ({1'b0, v} < c) ? {1'b0, v} : c;
   endfunction

   always_comb begin
      pos_in = pos_ff; hdr_in = hdr_ff; ph_in = ph_ff; rbi_in = rbi_ff;
      dsta_in = dsta_ff; dnet_in = dnet_ff; csta_in = csta_ff; cnet_in = cnet_ff;
      prf_in = prf_ff; bf0_in = bf0_ff; bf1_in = bf1_ff;
      rbi_nx = rbi_ff + 4'd1;
      cnt_nx = 8'd0;
      if (acc && inrange) begin
         if (pos_ff < pmfp_pkg::PosW'(8)) hdr_in[pos_ff[2:0]] = b;
         pos_in = pos_ff + 1'b1;
         if (pos_ff >= pmfp_pkg::PosW'(5)) begin
            if (mt == pmfp_pkg::MtDiscList) begin
               if (p == '0) begin
                  dsta_in = b; rbi_in = '0;
                  ph_in = (capped(b, record_cap) != 9'd0) ? pmfp_pkg::PH_STA
                                                          : pmfp_pkg::PH_NETCNT;
               end else begin
                  case (ph_ff)
                     pmfp_pkg::PH_STA: begin
                        if (rbi_ff == 4'd0) prf_in = b;
                        rbi_in = rbi_nx;
                        if (rbi_nx >= pmfp_pkg::StaRecLen) begin
                           rbi_in = '0;
                           cnt_nx = csta_ff + 8'd1;
                           csta_in = cnt_nx;
                           if ({1'b0, cnt_nx} >= capped(dsta_ff, record_cap))
                              ph_in = pmfp_pkg::PH_NETCNT;
                        end
                     end
                     pmfp_pkg::PH_NETCNT: begin
                        dnet_in = b; rbi_in = '0;
                        ph_in = (capped(b, record_cap) != 9'd0) ? pmfp_pkg::PH_NET
                                                                : pmfp_pkg::PH_DONE;
                     end
                     pmfp_pkg::PH_NET: begin
                        rbi_in = rbi_nx;
                        if (rbi_nx >= pmfp_pkg::NetRecLen) begin
                           rbi_in = '0;
                           cnt_nx = cnet_ff + 8'd1;
                           cnet_in = cnt_nx;
                           if ({1'b0, cnt_nx} >= capped(dnet_ff, record_cap))
                              ph_in = pmfp_pkg::PH_DONE;
                        end
                     end
                     default: ;
                  endcase
               end
            end else if (mt == pmfp_pkg::MtSetKey) begin
               if (p == '0) bf0_in = b;
               else if (p == pmfp_pkg::PosW'(9)) bf1_in = b;
            end else if (mt == pmfp_pkg::MtBridge) begin
               if (p == '0) bf0_in = b;
               else if (p == pmfp_pkg::PosW'(1)) bf1_in = b;
               else if (p == pmfp_pkg::PosW'(2)) begin
                  dsta_in = b;
                  if (bf0_ff != 8'd0 && capped(b, record_cap) != 9'd0) begin
                     ph_in = pmfp_pkg::PH_BRG; rbi_in = '0;
                  end
               end else if (ph_ff == pmfp_pkg::PH_BRG) begin
                  rbi_in = rbi_nx;
                  if (rbi_nx >= pmfp_pkg::BrgRecLen) begin
                     rbi_in = '0;
                     cnt_nx = csta_ff + 8'd1;
                     csta_in = cnt_nx;
                     if ({1'b0, cnt_nx} >= capped(dsta_ff, record_cap))
                        ph_in = pmfp_pkg::PH_DONE;
                  end
               end
            end
         end
      end
   end

   // result from the updated state
   always_comb begin
      logic [7:0] ndecl;
      n = pos_in;
      res_in = '0;
      cat = hdr_in[2][7:5];
      vend = (cat == 3'd4) || (cat == 3'd5);
      shorth = (hdr_in[0] == 8'd0) && vend;
      oui = '0;
      ndecl = dnet_in;
      if (n < pmfp_pkg::PosW'(3)) begin
         off = '0;
         res_in.frame_status = pmfp_pkg::StTiny;
      end else begin
         res_in.version = hdr_in[0];
         res_in.message_type = {hdr_in[2], hdr_in[1]};
         res_in.flags[0] = hdr_in[0] <= 8'd2;
         res_in.flags[1] = pmfp_pkg::known_type({hdr_in[2], hdr_in[1]});
         if (shorth) off = pmfp_pkg::PosW'(3);
         else if (n < pmfp_pkg::PosW'(5)) begin
            off = n; res_in.frame_status = pmfp_pkg::StHdrShort;
         end else begin
            off = pmfp_pkg::PosW'(5);
            res_in.fragment_info = {hdr_in[3], hdr_in[4]};
         end
         if (vend && off < n) begin
            if (n - off >= pmfp_pkg::PosW'(3)) begin
               // off is 3 or 5 here
               if (off[1]) oui = {hdr_in[3], hdr_in[4], hdr_in[5]};
               else        oui = {hdr_in[5], hdr_in[6], hdr_in[7]};
               res_in.vendor_oui = oui;
               res_in.oui_class = (oui == pmfp_pkg::OuiVendA) ? 2'd2 :
                                  (oui == pmfp_pkg::OuiVendB) ? 2'd3 : 2'd1;
               off = off + pmfp_pkg::PosW'(3);
            end else res_in.frame_status = pmfp_pkg::StOuiShort;
         end
         res_in.header_bytes = off[3:0];
      end
      plen = 12'(n - off);
      if (n >= pmfp_pkg::PosW'(3)) begin
         res_in.pay_len = plen;
         if (res_in.message_type == pmfp_pkg::MtDiscList && plen != 12'd0) begin
            res_in.body_kind = pmfp_pkg::BkDisc;
            if (ph_in == pmfp_pkg::PH_STA && rbi_in != 4'd0) ndecl = prf_in;
            res_in.flags[2] = csta_in < dsta_in;
            res_in.flags[3] = cnet_in < ndecl;
            res_in.body_first = csta_in;
            res_in.body_second = cnet_in;
         end else if (res_in.message_type == pmfp_pkg::MtSetKey
                      && plen >= pmfp_pkg::KeyMinLen) begin
            res_in.body_kind = pmfp_pkg::BkKey;
            res_in.body_first = {5'd0, bf0_in[2:0]};
            res_in.body_second = bf1_in;
         end else if (res_in.message_type == pmfp_pkg::MtBridge && plen != 12'd0) begin
            res_in.body_kind = pmfp_pkg::BkBridge;
            if (bf0_in != 8'd0) begin
               res_in.flags[4] = 1'b1;
               if (plen >= 12'd3) begin
                  res_in.body_first = csta_in;
                  res_in.body_second = bf1_in;
                  res_in.flags[2] = csta_in < dsta_in;
               end
            end
         end
      end
      ov_in = ov_ff;
      if (out_ready) ov_in = 1'b0;
      if (acc && in_word.last) ov_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (acc && in_word.last) res_ff <= res_in;
      if (reset || (acc && in_word.last)) begin
         pos_ff <= '0;
         for (int i = 0; i < 8; i++) hdr_ff[i] <= '0;
         ph_ff <= pmfp_pkg::PH_IDLE; rbi_ff <= '0;
         dsta_ff <= '0; dnet_ff <= '0; csta_ff <= '0; cnet_ff <= '0;
         prf_ff <= '0; bf0_ff <= '0; bf1_ff <= '0;
      end else begin
         pos_ff <= pos_in; hdr_ff <= hdr_in; ph_ff <= ph_in; rbi_ff <= rbi_in;
         dsta_ff <= dsta_in; dnet_ff <= dnet_in; csta_ff <= csta_in; cnet_ff <= cnet_in;
         prf_ff <= prf_in; bf0_ff <= bf0_in; bf1_ff <= bf1_in;
      end
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= ov_in;
   end
endmodule
`default_nettype wire
